FILE: src/cbe_pkg.sv
// shared types, constants and control structs of the charstring byte encryptor
package cbe_pkg;

    typedef logic [7:0]        byte_t;
    typedef logic [15:0]       key_t;
    typedef logic [4:0]        count_t;
    typedef logic [3:0]        tbl_idx_t;
    typedef logic signed [5:0] prefix_len_t;

    localparam int TableDepth = 10;
    localparam int BumpCount  = 5;

    localparam key_t KEY_INIT = 16'd4330;
    localparam key_t KEY_MUL  = 16'd52845;
    localparam key_t KEY_ADD  = 16'd22719;

    localparam prefix_len_t PREFIX_RESET     = 6'sd4;
    localparam prefix_len_t PREFIX_MAX_LEN   = 6'sd16;
    localparam prefix_len_t PASS_THROUGH_LEN = -6'sd1;

    localparam count_t COUNT_MAX   = 5'd16;
    localparam count_t COUNT_DEPTH = 5'(TableDepth);

    localparam byte_t TABLE_RESET [TableDepth] = '{
        8'haa, 8'h55, 8'h3e, 8'h4d, 8'h89, 8'h98, 8'h61, 8'h34, 8'h00, 8'hff
    };
    localparam byte_t TABLE_BUMP [BumpCount] = '{
        8'd3, 8'd5, 8'd7, 8'd11, 8'd13
    };

    typedef struct packed {
        logic     bump;
        tbl_idx_t idx;
    } tbl_ctrl_t;

    typedef struct packed {
        logic restart;
        logic advance;
    } key_ctrl_t;

endpackage

FILE: src/cbe_prefix_table.sv
// pseudo-random prefix table with start-of-string bump and one read port
module cbe_prefix_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbe_pkg::tbl_ctrl_t ctrl,
    output cbe_pkg::byte_t    rd_data
);

    cbe_pkg::byte_t table_reg [cbe_pkg::TableDepth];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cbe_pkg::TableDepth; i++) begin
                table_reg[i] <= cbe_pkg::TABLE_RESET[i];
            end
        end else if (ctrl.bump) begin
            for (int i = 0; i < cbe_pkg::BumpCount; i++) begin
                table_reg[i] <= table_reg[i] + cbe_pkg::TABLE_BUMP[i];
            end
        end
    end

    assign rd_data = table_reg[ctrl.idx];

endmodule

FILE: src/cbe_key_cipher.sv
// key register and byte cipher: c = p ^ key[15:8], key = (c + key) * mul + add
module cbe_key_cipher (
    input  logic               aclk,
    input  logic               aresetn,
    input  cbe_pkg::key_ctrl_t ctrl,
    input  cbe_pkg::byte_t     plain,
    output cbe_pkg::byte_t     cipher
);

    cbe_pkg::key_t key_reg;
    cbe_pkg::key_t key_next;
    cbe_pkg::key_t key_sum;
    cbe_pkg::key_t key_prod;

    assign cipher   = plain ^ key_reg[15:8];
    assign key_sum  = key_reg + {8'd0, cipher};
    // only the low 16 bits of the product reach the key
    assign key_prod = key_sum * cbe_pkg::KEY_MUL;

    always_comb begin
        key_next = key_reg;
        if (ctrl.restart) begin
            key_next = cbe_pkg::KEY_INIT;
        end else if (ctrl.advance) begin
            key_next = key_prod + cbe_pkg::KEY_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= cbe_pkg::KEY_INIT;
        end else begin
            key_reg <= key_next;
        end
    end

endmodule

FILE: src/charstring_byte_encryptor.sv
// an accepted item is held in the input register, and each of its results is registered in the output register
// throughput: one result per cycle while the output is not stalled; a string start with n prefix bytes
//   sends them before its own byte and holds the input until that byte goes, since each key update needs the last
// reset (aresetn low, synchronous): key 4330, prefix table to its start values,
//   prefix length 4, both channels empty
module charstring_byte_encryptor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  cbe_pkg::prefix_len_t cfg_wdata,  // prefix_length
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // plain_byte
    input  logic                s_tuser,    // first_of_string
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // cipher_byte
    output logic                m_tlast     // last_of_run
);

    cbe_pkg::prefix_len_t prefix_len_reg;
    logic                 in_valid_reg;
    cbe_pkg::byte_t       in_byte_reg;
    cbe_pkg::count_t      count_reg;
    cbe_pkg::count_t      count_next;
    cbe_pkg::count_t      load_count;
    cbe_pkg::count_t      wrap_count;
    logic                 m_tvalid_reg;
    cbe_pkg::byte_t       m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 pass_mode;
    logic                 advance;
    logic                 is_last;
    logic                 s_fire;
    cbe_pkg::byte_t       enc_plain;
    cbe_pkg::byte_t       enc_cipher;
    cbe_pkg::byte_t       tbl_data;
    cbe_pkg::byte_t       out_byte;
    cbe_pkg::tbl_ctrl_t   tbl_ctrl;
    cbe_pkg::key_ctrl_t   key_ctrl;

    assign pass_mode = (prefix_len_reg == cbe_pkg::PASS_THROUGH_LEN);
    assign advance   = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign is_last   = (count_reg == '0);
    assign s_tready  = !in_valid_reg || (advance && is_last);
    assign s_fire    = s_tvalid && s_tready;

    // prefix count for a new item: only a string start gets one, capped at sixteen; negative lengths give none
    always_comb begin
        load_count = '0;
        if (s_tuser && !pass_mode && (prefix_len_reg > 6'sd0)) begin
            if (prefix_len_reg > cbe_pkg::PREFIX_MAX_LEN) begin
                load_count = cbe_pkg::COUNT_MAX;
            end else begin
                load_count = prefix_len_reg[4:0];
            end
        end
    end

    // table index is the count mod ten, count is at most sixteen
    assign wrap_count = (count_reg >= cbe_pkg::COUNT_DEPTH) ?
                        (count_reg - cbe_pkg::COUNT_DEPTH) : count_reg;

    assign tbl_ctrl.bump = s_fire && s_tuser && !pass_mode;
    assign tbl_ctrl.idx  = wrap_count[3:0];

    assign key_ctrl.restart = s_fire && s_tuser;
    assign key_ctrl.advance = advance && !(is_last && pass_mode);

    assign enc_plain = is_last ? in_byte_reg : tbl_data;
    assign out_byte  = (is_last && pass_mode) ? in_byte_reg : enc_cipher;

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            count_next = load_count;
        end else if (advance && !is_last) begin
            count_next = count_reg - 5'd1;
        end
    end

    cbe_prefix_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tbl_ctrl),
        .rd_data (tbl_data)
    );

    cbe_key_cipher u_key (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (key_ctrl),
        .plain   (enc_plain),
        .cipher  (enc_cipher)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_len_reg <= cbe_pkg::PREFIX_RESET;
            in_valid_reg   <= 1'b0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                prefix_len_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance && is_last) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            m_tdata_reg <= out_byte;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cbe_pkg::COUNT_MAX)
        else $error("prefix count out of range");

    a_hold_in_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (count_reg != '0)) |-> !s_tready)
        else $error("input taken while prefix bytes pending");

    a_pass_no_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && pass_mode) |=> (count_reg == '0))
        else $error("prefix scheduled in pass-through mode");

    a_prefix_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_last) |=> (m_tvalid && !m_tlast))
        else $error("prefix byte marked last");
`endif

endmodule
